FILE: hdl/iheap_pkg.sv
`default_nettype none
package iheap_pkg;

  localparam int unsigned NodeCountDef = 1024;
  localparam int unsigned KeyBitsDef   = 32;
  localparam int unsigned NodeIdBits   = 10;
  localparam int unsigned OutKeyBits   = 32;
  localparam int unsigned KindBits     = 2;
  localparam int unsigned StatusBits   = 3;
  localparam int unsigned TdataBits    = 48;

  typedef enum logic [KindBits-1:0] {
    KIND_OFFER   = 2'd0,
    KIND_EXTRACT = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [StatusBits-1:0] {
    ST_TAKEN     = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_EXTRACTED = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_CLEARED   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_OFFER,
    S_UP,
    S_UP_CMP,
    S_PLACE,
    S_EXT_TOP,
    S_EXT_LAST,
    S_DN,
    S_DN_CMP,
    S_RESP
  } state_e;

endpackage
`default_nettype wire

FILE: hdl/iheap_slot_ram.sv
`default_nettype none
module iheap_slot_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 42
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule
`default_nettype wire

FILE: hdl/iheap_node_ram.sv
`default_nettype none
module iheap_node_ram #(
  parameter int unsigned Depth   = 1024,
  parameter int unsigned KeyBits = 32,
  parameter int unsigned PosBits = 11
) (
  input  wire logic                     clk_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [KeyBits-1:0]       key_rdata_o,
  output logic      [PosBits-1:0]       pos_rdata_o,
  input  wire logic                     key_we_i,
  input  wire logic [$clog2(Depth)-1:0] key_waddr_i,
  input  wire logic [KeyBits-1:0]       key_wdata_i,
  input  wire logic                     pos_we_i,
  input  wire logic [$clog2(Depth)-1:0] pos_waddr_i,
  input  wire logic [PosBits-1:0]       pos_wdata_i
);

  logic [KeyBits-1:0] key_mem [Depth];
  logic [PosBits-1:0] pos_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (key_we_i) begin
      key_mem[key_waddr_i] <= key_wdata_i;
    end
    key_rdata_o <= key_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (pos_we_i) begin
      pos_mem[pos_waddr_i] <= pos_wdata_i;
    end
    pos_rdata_o <= pos_mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: hdl/indexed_min_heap_decrease_key_core.sv
`default_nettype none
// Indexed binary min-heap of node ids keyed by arrival time, with decrease-key. The item kind
// on s_axis_tuser selects an offer, an extract of the minimum, or a clear, and any other kind
// is ignored; every item returns exactly one result item. Heap entries and per-node keys and
// positions live in synchronous memories, and each sift level is a slot read followed by a
// compare and write back. After reset, and on every clear, a pass over every node rewrites
// the node memories; no item is taken during it, and a clear answers once the pass is over.
module indexed_min_heap_decrease_key_core
  import iheap_pkg::*;
#(
  parameter int unsigned NODE_COUNT = NodeCountDef,
  parameter int unsigned KEY_BITS   = KeyBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // Fields from bit 0: node_id[9:0], arrival_key[41:10], zero fill.
  input  wire logic [TdataBits-1:0]  s_axis_tdata,
  // Fields from bit 0: kind[1:0].
  input  wire logic [KindBits-1:0]   s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // Fields from bit 0: out_node[9:0], out_key[41:10], zero fill.
  output logic      [TdataBits-1:0]  m_axis_tdata,
  // Fields from bit 0: status[2:0].
  output logic      [StatusBits-1:0] m_axis_tuser
);

  localparam int unsigned NW = $clog2(NODE_COUNT);
  localparam int unsigned CW = $clog2(NODE_COUNT + 1);
  localparam int unsigned PW = $clog2(NODE_COUNT + 2);
  localparam int unsigned KW = KEY_BITS;
  localparam int unsigned SW = KW + NW;
  localparam logic [KW-1:0] KeyMask = {KW{1'b1}};
  localparam logic [PW-1:0] PosNone = PW'(NODE_COUNT);
  localparam logic [PW-1:0] PosDone = PW'(NODE_COUNT + 1);

  state_e state_q, state_d;
  kind_e kind_q, kind_d;
  logic [NodeIdBits-1:0] node_q, node_d;
  logic [KW-1:0] key_q, key_d;
  logic [NW-1:0] at_q, at_d;
  logic [NW-1:0] mv_node_q, mv_node_d;
  logic [KW-1:0] mv_key_q, mv_key_d;
  logic [CW-1:0] count_q, count_d;
  logic [NW-1:0] clr_idx_q, clr_idx_d;
  logic clr_reply_q, clr_reply_d;
  logic [NodeIdBits-1:0] res_node_q, res_node_d;
  logic [KW-1:0] res_key_q, res_key_d;
  status_e res_status_q, res_status_d;
  logic out_valid_q, out_valid_d;
  logic [NodeIdBits-1:0] out_node_q, out_node_d;
  logic [OutKeyBits-1:0] out_key_q, out_key_d;
  status_e out_status_q, out_status_d;

  logic slot_we;
  logic [NW-1:0] slot_waddr, slot_raddr_a, slot_raddr_b;
  logic [SW-1:0] slot_wdata, slot_rdata_a, slot_rdata_b;
  logic [NW-1:0] node_raddr, key_waddr, pos_waddr;
  logic [KW-1:0] node_key_rd, key_wdata;
  logic [PW-1:0] node_pos_rd, pos_wdata;
  logic key_we, pos_we;

  logic [63:0] in_key_wide, res_key_wide;
  logic [KW-1:0] in_key_sat;
  logic in_range;
  logic [NW:0] child;
  logic [CW-1:0] last;
  logic [NW-1:0] child_a, child_b, pick_idx;
  logic [NW-1:0] pick_node, a_node, b_node;
  logic [KW-1:0] pick_key, a_key, b_key;
  logic accept;

  iheap_slot_ram #(.Depth(NODE_COUNT), .Width(SW)) u_slot_ram (
    .clk_i    (clk_i),
    .we_i     (slot_we),
    .waddr_i  (slot_waddr),
    .wdata_i  (slot_wdata),
    .raddr_a_i(slot_raddr_a),
    .raddr_b_i(slot_raddr_b),
    .rdata_a_o(slot_rdata_a),
    .rdata_b_o(slot_rdata_b)
  );

  iheap_node_ram #(.Depth(NODE_COUNT), .KeyBits(KW), .PosBits(PW)) u_node_ram (
    .clk_i      (clk_i),
    .raddr_i    (node_raddr),
    .key_rdata_o(node_key_rd),
    .pos_rdata_o(node_pos_rd),
    .key_we_i   (key_we),
    .key_waddr_i(key_waddr),
    .key_wdata_i(key_wdata),
    .pos_we_i   (pos_we),
    .pos_waddr_i(pos_waddr),
    .pos_wdata_i(pos_wdata)
  );

  assign in_key_wide = 64'(s_axis_tdata[41:10]);
  assign in_key_sat = (in_key_wide > 64'(KeyMask)) ? KeyMask : in_key_wide[KW-1:0];
  assign in_range = 32'(node_q) < 32'(NODE_COUNT);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  assign child = {at_q, 1'b1};
  assign last = count_q - CW'(1);
  assign child_a = child[NW-1:0];
  assign child_b = child_a + NW'(1);
  assign a_node = slot_rdata_a[NW-1:0];
  assign a_key = slot_rdata_a[SW-1:NW];
  assign b_node = slot_rdata_b[NW-1:0];
  assign b_key = slot_rdata_b[SW-1:NW];

  always_comb begin
    if ((32'(child) < 32'(last)) && (b_key < a_key)) begin
      pick_idx = child_b;
      pick_node = b_node;
      pick_key = b_key;
    end else begin
      pick_idx = child_a;
      pick_node = a_node;
      pick_key = a_key;
    end
  end

  assign res_key_wide = 64'(res_key_q);

  always_comb begin
    state_d = state_q;
    kind_d = kind_q;
    node_d = node_q;
    key_d = key_q;
    at_d = at_q;
    mv_node_d = mv_node_q;
    mv_key_d = mv_key_q;
    count_d = count_q;
    clr_idx_d = clr_idx_q;
    clr_reply_d = clr_reply_q;
    res_node_d = res_node_q;
    res_key_d = res_key_q;
    res_status_d = res_status_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_node_d = out_node_q;
    out_key_d = out_key_q;
    out_status_d = out_status_q;
    slot_we = 1'b0;
    slot_waddr = at_q;
    slot_wdata = {mv_key_q, mv_node_q};
    slot_raddr_a = '0;
    slot_raddr_b = child_b;
    node_raddr = NW'(s_axis_tdata[NodeIdBits-1:0]);
    key_we = 1'b0;
    key_waddr = NW'(node_q);
    key_wdata = key_q;
    pos_we = 1'b0;
    pos_waddr = mv_node_q;
    pos_wdata = PW'(at_q);

    case (state_q)
      S_CLR: begin
        key_we = 1'b1;
        key_waddr = clr_idx_q;
        key_wdata = KeyMask;
        pos_we = 1'b1;
        pos_waddr = clr_idx_q;
        pos_wdata = PosNone;
        count_d = '0;
        clr_idx_d = clr_idx_q + NW'(1);
        if (32'(clr_idx_q) == 32'(NODE_COUNT - 1)) begin
          clr_idx_d = '0;
          if (clr_reply_q) begin
            res_node_d = '0;
            res_key_d = '0;
            res_status_d = ST_CLEARED;
            state_d = S_RESP;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          kind_d = kind_e'(s_axis_tuser);
          node_d = s_axis_tdata[NodeIdBits-1:0];
          key_d = in_key_sat;
          res_node_d = '0;
          res_key_d = '0;
          res_status_d = ST_IGNORED;
          case (kind_e'(s_axis_tuser))
            KIND_OFFER: state_d = S_OFFER;
            KIND_EXTRACT: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
                state_d = S_RESP;
              end else begin
                state_d = S_EXT_TOP;
              end
            end
            KIND_CLEAR: begin
              clr_reply_d = 1'b1;
              clr_idx_d = '0;
              state_d = S_CLR;
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_OFFER: begin
        res_node_d = node_q;
        res_key_d = in_range ? node_key_rd : '0;
        res_status_d = ST_IGNORED;
        state_d = S_RESP;
        if (in_range && (node_pos_rd != PosDone) && (key_q < node_key_rd)) begin
          key_we = 1'b1;
          res_key_d = key_q;
          res_status_d = ST_TAKEN;
          mv_node_d = NW'(node_q);
          mv_key_d = key_q;
          if (32'(node_pos_rd) < 32'(count_q)) begin
            at_d = NW'(node_pos_rd);
            state_d = S_UP;
          end else if (32'(count_q) < 32'(NODE_COUNT)) begin
            at_d = NW'(count_q);
            count_d = count_q + CW'(1);
            state_d = S_UP;
          end
        end
      end
      S_UP: begin
        slot_raddr_a = (at_q - NW'(1)) >> 1;
        state_d = (at_q == '0) ? S_PLACE : S_UP_CMP;
      end
      S_UP_CMP: begin
        if (mv_key_q < a_key) begin
          slot_we = 1'b1;
          slot_wdata = slot_rdata_a;
          pos_we = 1'b1;
          pos_waddr = a_node;
          at_d = (at_q - NW'(1)) >> 1;
          state_d = S_UP;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        slot_we = 1'b1;
        pos_we = 1'b1;
        state_d = S_RESP;
      end
      S_EXT_TOP: begin
        res_node_d = NodeIdBits'(a_node);
        res_key_d = a_key;
        res_status_d = ST_EXTRACTED;
        pos_we = 1'b1;
        pos_waddr = a_node;
        pos_wdata = PosDone;
        count_d = last;
        slot_raddr_a = NW'(last);
        state_d = (last == '0) ? S_RESP : S_EXT_LAST;
      end
      S_EXT_LAST: begin
        mv_node_d = a_node;
        mv_key_d = a_key;
        at_d = '0;
        state_d = S_DN;
      end
      S_DN: begin
        slot_raddr_a = child_a;
        state_d = (32'(child) > 32'(last)) ? S_PLACE : S_DN_CMP;
      end
      S_DN_CMP: begin
        if (pick_key < mv_key_q) begin
          slot_we = 1'b1;
          slot_wdata = {pick_key, pick_node};
          pos_we = 1'b1;
          pos_waddr = pick_node;
          at_d = pick_idx;
          state_d = S_DN;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_node_d = res_node_q;
          out_key_d = res_key_wide[OutKeyBits-1:0];
          out_status_d = res_status_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      count_q <= '0;
      clr_idx_q <= '0;
      clr_reply_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      clr_idx_q <= clr_idx_d;
      clr_reply_q <= (state_q == S_CLR) ? clr_reply_q : clr_reply_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    node_q <= node_d;
    key_q <= key_d;
    at_q <= at_d;
    mv_node_q <= mv_node_d;
    mv_key_q <= mv_key_d;
    res_node_q <= res_node_d;
    res_key_q <= res_key_d;
    res_status_q <= res_status_d;
    out_node_q <= out_node_d;
    out_key_q <= out_key_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {6'd0, out_key_q, out_node_q};
  assign m_axis_tuser = out_status_q;

endmodule
`default_nettype wire

FILE: sim/indexed_min_heap_decrease_key_core_test.sv
module indexed_min_heap_decrease_key_core_test;
  import iheap_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Nodes = 1024;
  localparam logic [31:0] Unreached = 32'hFFFF_FFFF;
  localparam int unsigned CycleLimit = 2_000_000;

  typedef struct packed {
    logic [9:0]  node;
    logic [31:0] key;
    status_e     status;
  } heap_result_t;

  class heap_scoreboard;
    logic [9:0]  slots [Nodes];
    int unsigned count;
    logic [31:0] keys [Nodes];
    int unsigned position [Nodes];
    bit          done [Nodes];
    heap_result_t pending [$];
    int unsigned mismatches;

    function void clear_all();
      count = 0;
      for (int n = 0; n < Nodes; n++) begin
        slots[n] = '0;
        keys[n] = Unreached;
        position[n] = Nodes;
        done[n] = 0;
      end
    endfunction

    function void sift_up(int unsigned at);
      logic [9:0] mover;
      int unsigned parent;
      mover = slots[at];
      while (at > 0) begin
        parent = (at - 1) >> 1;
        if (keys[mover] < keys[slots[parent]]) begin
          slots[at] = slots[parent];
          position[slots[at]] = at;
          at = parent;
        end else begin
          break;
        end
      end
      slots[at] = mover;
      position[mover] = at;
    endfunction

    function void sift_down(int unsigned at);
      logic [9:0] mover;
      int unsigned child, last;
      mover = slots[at];
      last = count - 1;
      child = 2 * at + 1;
      while (child <= last) begin
        if (child < last && keys[slots[child + 1]] < keys[slots[child]]) child++;
        if (keys[slots[child]] < keys[mover]) begin
          slots[at] = slots[child];
          position[slots[at]] = at;
          at = child;
          child = 2 * child + 1;
        end else begin
          break;
        end
      end
      slots[at] = mover;
      position[mover] = at;
    endfunction

    function void note_item(kind_e kind, logic [9:0] node, logic [31:0] key);
      heap_result_t r;
      r = '{node: '0, key: '0, status: ST_IGNORED};
      case (kind)
        KIND_OFFER: begin
          r.node = node;
          r.key = keys[node];
          if (!done[node] && key < keys[node]) begin
            keys[node] = key;
            r.key = key;
            r.status = ST_TAKEN;
            if (position[node] < count) begin
              sift_up(position[node]);
            end else if (count < Nodes) begin
              slots[count] = node;
              position[node] = count;
              count++;
              sift_up(count - 1);
            end
          end
        end
        KIND_EXTRACT: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.node = slots[0];
            r.key = keys[slots[0]];
            r.status = ST_EXTRACTED;
            done[slots[0]] = 1;
            position[slots[0]] = Nodes;
            count--;
            if (count > 0) begin
              slots[0] = slots[count];
              position[slots[0]] = 0;
              sift_down(0);
            end
          end
        end
        KIND_CLEAR: begin
          clear_all();
          r.status = ST_CLEARED;
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(heap_result_t got);
      heap_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.node !== want.node || got.key !== want.key || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected node %0d key %h status %0d, got node %0d key %h status %0d",
                   want.node, want.key, want.status, got.node, got.key, got.status);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [TdataBits-1:0] s_axis_tdata = '0;
  logic [KindBits-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [TdataBits-1:0] m_axis_tdata;
  logic [StatusBits-1:0] m_axis_tuser;

  heap_scoreboard board;
  bit quiet_tail = 0;
  int unsigned cycles = 0;

  indexed_min_heap_decrease_key_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result('{node: m_axis_tdata[9:0], key: m_axis_tdata[41:10],
                           status: status_e'(m_axis_tuser)});
  end

  initial begin
    int gap;
    @(posedge clk_i);
    forever begin
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 11);
        m_axis_tready <= 0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      @(posedge clk_i);
    end
  end

  task automatic send_item(kind_e kind, logic [9:0] node, logic [31:0] key);
    int gap;
    if (!quiet_tail && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {6'd0, key, node};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(kind, node, key);
  endtask

  task automatic send_offer(logic [9:0] node, logic [31:0] key);
    send_item(KIND_OFFER, node, key);
  endtask

  function automatic logic [31:0] random_key();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 15);
      1: return Unreached - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned pick, base;
    board = new();
    board.clear_all();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;

    send_item(KIND_EXTRACT, 10'd0, 32'd0);
    send_offer(10'd0, 32'd0);
    send_offer(10'd1023, Unreached);
    send_offer(10'd1023, Unreached - 1);
    send_offer(10'd5, 32'd100);
    send_offer(10'd6, 32'd100);
    send_offer(10'd7, 32'd50);
    send_offer(10'd5, 32'd100);
    send_offer(10'd5, 32'd10);
    send_offer(10'd6, 32'd200);
    send_item(KIND_NONE, 10'h3FF, Unreached);
    repeat (6) send_item(KIND_EXTRACT, 10'd0, 32'd0);
    send_offer(10'd0, 32'd0);
    send_offer(10'd5, 32'd1);
    send_offer(10'h2AA, 32'hAAAA_AAAA);
    send_offer(10'h155, 32'h5555_5555);
    send_item(KIND_CLEAR, 10'd0, 32'd0);
    send_offer(10'd0, 32'd7);
    send_item(KIND_EXTRACT, 10'd0, 32'd0);
    s_axis_tvalid <= 0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    for (int i = 0; i < 1080; i++) begin
      if (i == 900) quiet_tail = 1;
      if (i % 150 == 0) base = $urandom_range(0, 1023 - 40);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 9) == 0) send_offer(10'($urandom), random_key());
        else send_offer(10'(base + $urandom_range(0, 40)), random_key());
      end else if (pick < 96) begin
        send_item(KIND_EXTRACT, 10'($urandom), $urandom);
      end else if (pick < 98) begin
        send_item(KIND_CLEAR, 10'($urandom), $urandom);
      end else begin
        send_item(KIND_NONE, 10'($urandom), $urandom);
      end
    end
    for (int n = 0; n < 20; n++) send_offer(10'(n + 500), random_key());
    repeat (22) send_item(KIND_EXTRACT, 10'd0, 32'd0);
    s_axis_tvalid <= 0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
